FILE: hw/rtl/sfr_pkg.sv
`timescale 1ns / 1ps
// Package for the streaming find-and-replace block: beat payload types,
// configuration register indexes and size constants. No dependencies.

package sfr_pkg;

  localparam int unsigned MAX_PATTERN     = 16;
  localparam int unsigned MAX_REPLACEMENT = 16;
  localparam int unsigned WIN_SLOTS       = 16;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_LOW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_HIGH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_LENGTH = 3'd5;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } sfr_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_present;
    logic       end_of_text;
    logic       last_of_run;
  } sfr_out_t;

endpackage

FILE: hw/rtl/sfr_if.sv
`timescale 1ns / 1ps
// Valid/ready stream interfaces for the input and result channels.
// Depends on sfr_pkg for the payload types.

interface sfr_in_if;
  logic            valid;
  logic            ready;
  sfr_pkg::sfr_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sfr_out_if;
  logic             valid;
  logic             ready;
  sfr_pkg::sfr_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/stream_find_replace.sv
`timescale 1ns / 1ps
// Streaming find-and-replace: top level with window, sequencer and output stage.
// Depends on sfr_pkg and the stream interfaces in sfr_if.sv.
//
//   Port        Dir   Kind                Content
//   in_i        in    valid/ready beat    text_byte, final_byte
//   out_o       out   valid/ready beat    out_byte, byte_present, end_of_text, last_of_run
//   cfg_*_i     in    write enable/index  six configuration registers
//
// An input beat is taken while idle and scanned against the pattern; each result it
// causes is then produced in turn, and a final beat also flushes the window. The single
// window compare unit evaluates the pending window once per cycle.
// Output stalls hold up the sequencer while a result waits in the output register.
// Reset is asynchronous and active low and needs no clearing pass.
// The input is ready only while the sequencer is idle.

module stream_find_replace (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  sfr_in_if.sink                              in_i,
  sfr_out_if.source                           out_o,
  input  logic                                cfg_we_i,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam logic [4:0] PLEN_CAP =
    5'((sfr_pkg::MAX_PATTERN < 16) ? sfr_pkg::MAX_PATTERN : 16);
  localparam logic [4:0] RLEN_CAP =
    5'((sfr_pkg::MAX_REPLACEMENT < 16) ? sfr_pkg::MAX_REPLACEMENT : 16);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REPL,
    ST_FLUSH,
    ST_DONE
  } state_e;

  function automatic logic [4:0] sat_plen(input logic [4:0] n);
    logic [4:0] r;
    r = (n == 5'd0) ? 5'd1 : n;
    return (r > PLEN_CAP) ? PLEN_CAP : r;
  endfunction

  function automatic logic [4:0] sat_rlen(input logic [4:0] n);
    return (n > RLEN_CAP) ? RLEN_CAP : n;
  endfunction

  state_e            state_q, state_d;
  logic [4:0]        cnt_q, cnt_d;
  logic [4:0]        rix_q, rix_d;
  logic              fin_q, fin_d;
  logic              hold_v_q, hold_v_d;
  logic [7:0]        hold_byte_q, hold_byte_d;
  logic              hold_pres_q, hold_pres_d;
  logic              ovalid_q, ovalid_d;
  sfr_pkg::sfr_out_t obeat_q, obeat_d;
  logic [7:0]        win_q [sfr_pkg::WIN_SLOTS];
  logic [7:0]        win_d [sfr_pkg::WIN_SLOTS];

  logic [63:0] pat_lo_q, pat_lo_d, pat_hi_q, pat_hi_d;
  logic [63:0] rep_lo_q, rep_lo_d, rep_hi_q, rep_hi_d;
  logic [4:0]  plen_q, plen_d, rlen_q, rlen_d;

  logic [15:0][7:0] pat_bytes;
  logic [15:0][7:0] rep_bytes;
  logic [15:0]      lane_ok;
  logic             is_prefix;
  logic             can_push;
  logic             gen_ok;
  logic             gen_fire;
  logic [7:0]       gen_byte;
  logic [4:0]       base_cnt;

  assign pat_bytes = {pat_hi_q, pat_lo_q};
  assign rep_bytes = {rep_hi_q, rep_lo_q};

  // The single compare unit: checks the whole pending window against the
  // pattern prefix in one pass.
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      lane_ok[i] = (5'(i) >= cnt_q) || (win_q[i] == pat_bytes[i]);
    end
    is_prefix = (cnt_q <= plen_q) && (&lane_ok);
  end

  assign can_push = !ovalid_q || out_o.ready;
  assign gen_ok   = !hold_v_q || can_push;
  assign base_cnt = (cnt_q >= plen_q) ? 5'd0 : cnt_q;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign out_o.valid = ovalid_q;
  assign out_o.data  = obeat_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rix_d       = rix_q;
    fin_d       = fin_q;
    hold_v_d    = hold_v_q;
    hold_byte_d = hold_byte_q;
    hold_pres_d = hold_pres_q;
    ovalid_d    = ovalid_q;
    obeat_d     = obeat_q;
    win_d       = win_q;
    pat_lo_d    = pat_lo_q;
    pat_hi_d    = pat_hi_q;
    rep_lo_d    = rep_lo_q;
    rep_hi_d    = rep_hi_q;
    plen_d      = plen_q;
    rlen_d      = rlen_q;
    gen_fire    = 1'b0;
    gen_byte    = 8'd0;

    if (ovalid_q && out_o.ready) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          win_d[base_cnt[3:0]] = in_i.data.text_byte;
          cnt_d                = base_cnt + 5'd1;
          fin_d                = in_i.data.final_byte;
          state_d              = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if ((cnt_q == plen_q) && is_prefix) begin
          cnt_d = 5'd0;
          rix_d = 5'd0;
          if (rlen_q == 5'd0) begin
            state_d = fin_q ? ST_FLUSH : ST_DONE;
          end else begin
            state_d = ST_REPL;
          end
        end else if ((cnt_q != 5'd0) && !is_prefix) begin
          if (gen_ok) begin
            gen_fire = 1'b1;
            gen_byte = win_q[0];
            for (int i = 0; i < 15; i++) begin
              win_d[i] = win_q[i+1];
            end
            cnt_d = cnt_q - 5'd1;
          end
        end else begin
          state_d = fin_q ? ST_FLUSH : ST_DONE;
        end
      end
      ST_REPL: begin
        if (gen_ok) begin
          gen_fire = 1'b1;
          gen_byte = rep_bytes[rix_q[3:0]];
          rix_d    = rix_q + 5'd1;
          if ((rix_q + 5'd1) == rlen_q) begin
            state_d = fin_q ? ST_FLUSH : ST_DONE;
          end
        end
      end
      ST_FLUSH: begin
        if (cnt_q != 5'd0) begin
          if (gen_ok) begin
            gen_fire = 1'b1;
            gen_byte = win_q[0];
            for (int i = 0; i < 15; i++) begin
              win_d[i] = win_q[i+1];
            end
            cnt_d = cnt_q - 5'd1;
          end
        end else begin
          if (!hold_v_q) begin
            hold_v_d    = 1'b1;
            hold_byte_d = 8'd0;
            hold_pres_d = 1'b0;
          end
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!hold_v_q) begin
          state_d = ST_IDLE;
        end else if (can_push) begin
          ovalid_d = 1'b1;
          obeat_d  = '{out_byte: hold_byte_q, byte_present: hold_pres_q,
                       end_of_text: fin_q, last_of_run: 1'b1};
          hold_v_d = 1'b0;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // A new result pushes the one held before it, which is then known not
    // to be the last of the run.
    if (gen_fire) begin
      if (hold_v_q) begin
        ovalid_d = 1'b1;
        obeat_d  = '{out_byte: hold_byte_q, byte_present: hold_pres_q,
                     end_of_text: 1'b0, last_of_run: 1'b0};
      end
      hold_v_d    = 1'b1;
      hold_byte_d = gen_byte;
      hold_pres_d = 1'b1;
    end

    if (cfg_we_i) begin
      case (cfg_idx_i)
        sfr_pkg::CFG_PATTERN_LOW: begin
          pat_lo_d = cfg_data_i;
        end
        sfr_pkg::CFG_PATTERN_HIGH: begin
          pat_hi_d = cfg_data_i;
        end
        sfr_pkg::CFG_PATTERN_LENGTH: begin
          plen_d = sat_plen(cfg_data_i[4:0]);
          cnt_d  = 5'd0;
        end
        sfr_pkg::CFG_REPLACEMENT_LOW: begin
          rep_lo_d = cfg_data_i;
        end
        sfr_pkg::CFG_REPLACEMENT_HIGH: begin
          rep_hi_d = cfg_data_i;
        end
        sfr_pkg::CFG_REPLACEMENT_LENGTH: begin
          rlen_d = sat_rlen(cfg_data_i[4:0]);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= 5'd0;
      rix_q       <= 5'd0;
      fin_q       <= 1'b0;
      hold_v_q    <= 1'b0;
      hold_byte_q <= 8'd0;
      hold_pres_q <= 1'b0;
      ovalid_q    <= 1'b0;
      obeat_q     <= '0;
      pat_lo_q    <= '0;
      pat_hi_q    <= '0;
      rep_lo_q    <= '0;
      rep_hi_q    <= '0;
      plen_q      <= 5'd1;
      rlen_q      <= 5'd0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rix_q       <= rix_d;
      fin_q       <= fin_d;
      hold_v_q    <= hold_v_d;
      hold_byte_q <= hold_byte_d;
      hold_pres_q <= hold_pres_d;
      ovalid_q    <= ovalid_d;
      obeat_q     <= obeat_d;
      pat_lo_q    <= pat_lo_d;
      pat_hi_q    <= pat_hi_d;
      rep_lo_q    <= rep_lo_d;
      rep_hi_q    <= rep_hi_d;
      plen_q      <= plen_d;
      rlen_q      <= rlen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  a_idle_no_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !hold_v_q)
    else $error("held result left over while idle");

  a_idle_window_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (cnt_q < plen_q))
    else $error("pending window not shorter than the pattern while idle");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 5'd16)
    else $error("pending count out of range");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && obeat_q.end_of_text) |-> obeat_q.last_of_run)
    else $error("end of text not marked as last of run");

  a_marker_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !obeat_q.byte_present) |-> (obeat_q.end_of_text && obeat_q.out_byte == 8'd0))
    else $error("empty result that is not the end marker");

endmodule
